// ----- hw/rtl/txgb_pkg.sv -----
// Shared types and constants of the text grid buffer engine.
// Depends on nothing; the top level uses it by scoped names.
`default_nettype none

package txgb_pkg;

    typedef logic [7:0] t_glyph;

    localparam t_glyph BLANK_GLYPH = 8'h20;

    typedef enum logic [2:0] {
        MODE_FILL   = 3'd0,
        MODE_DRAW   = 3'd1,
        MODE_CLEAR  = 3'd2,
        MODE_SCROLL = 3'd3,
        MODE_READ   = 3'd4
    } t_mode;

endpackage

`default_nettype wire

// ----- hw/rtl/txgb_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the glyph store of the text grid buffer engine.
`default_nettype none

module txgb_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/text_grid_buffer_engine.sv -----
// Text grid buffer engine: a character grid held in one RAM, walked cell by cell.
// Depends on txgb_pkg and txgb_ram.
//
//   channel   direction   handshake                 payload
//   in        to block    i_in_valid / o_in_stall   mode, row, column, glyph, counts
//   out       from block  o_out_valid / i_out_stall read_glyph
//
// Draw writes its cell straight from idle, read waits on the registered RAM read, and
// unused modes only return a result. Fill, clear rectangle (clipped cells only) and
// scroll up walk the grid cell by cell, all bound by the single RAM write port.
// After reset the block blanks the grid and holds stall while it does so.
// One transfer in gives one transfer out; a new item is taken only once the previous
// result has been placed in the output register.
`default_nettype none

module text_grid_buffer_engine #(
    parameter int GRID_ROWS = 16,
    parameter int GRID_COLS = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [2:0] i_mode,
    input  wire logic [7:0] i_row_index,
    input  wire logic [7:0] i_col_index,
    input  wire logic [7:0] i_glyph_code,
    input  wire logic [7:0] i_row_count,
    input  wire logic [7:0] i_col_count,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_read_glyph
);

    localparam int RW     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int CW     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int AW     = RW + CW;
    localparam int DEPTH  = GRID_ROWS * (1 << CW);
    localparam logic [7:0] ROWS8 = 8'(GRID_ROWS);
    localparam logic [7:0] COLS8 = 8'(GRID_COLS);
    localparam logic [8:0] ROWS9 = 9'(GRID_ROWS);
    localparam logic [8:0] COLS9 = 9'(GRID_COLS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BLANK,
        ST_COPY,
        ST_COPY_LAST,
        ST_READ_WAIT,
        ST_RESULT
    } t_state;

    t_state               r_state, n_state;
    logic [7:0]           r_row, n_row;
    logic [7:0]           r_col, n_col;
    logic [7:0]           r_row_end, n_row_end;
    logic [7:0]           r_col_lo, n_col_lo;
    logic [7:0]           r_col_hi, n_col_hi;
    logic [7:0]           r_shift, n_shift;
    logic                 r_item, n_item;
    logic                 r_wr_pend, n_wr_pend;
    logic [AW-1:0]        r_wr_addr, n_wr_addr;
    logic                 r_inside, n_inside;
    txgb_pkg::t_glyph     r_result, n_result;
    logic                 r_out_valid, n_out_valid;
    txgb_pkg::t_glyph     r_out_glyph, n_out_glyph;

    logic                 accept;
    logic                 in_grid;
    logic [AW-1:0]        in_addr;
    logic [AW-1:0]        cur_addr;
    logic [AW-1:0]        src_addr;
    logic [7:0]           src_row;
    logic [8:0]           row_sum;
    logic [8:0]           col_sum;
    logic [7:0]           clr_row_end;
    logic [7:0]           clr_col_hi;
    logic                 col_last;
    logic                 row_last;
    logic                 scroll_full;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    txgb_pkg::t_glyph     ram_wdata;
    logic [AW-1:0]        ram_raddr;
    txgb_pkg::t_glyph     ram_rdata;

    txgb_ram #(
        .WIDTH  (8),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_read_glyph = r_out_glyph;

    assign accept      = i_in_valid && !o_in_stall;
    assign in_grid     = (i_row_index < ROWS8) && (i_col_index < COLS8);
    assign in_addr     = {i_row_index[RW-1:0], i_col_index[CW-1:0]};
    assign cur_addr    = {r_row[RW-1:0], r_col[CW-1:0]};
    assign src_row     = r_row + r_shift;
    assign src_addr    = {src_row[RW-1:0], r_col[CW-1:0]};
    assign row_sum     = {1'b0, i_row_index} + {1'b0, i_row_count};
    assign col_sum     = {1'b0, i_col_index} + {1'b0, i_col_count};
    assign clr_row_end = (row_sum > ROWS9) ? ROWS8 : row_sum[7:0];
    assign clr_col_hi  = (col_sum > COLS9) ? COLS8 : col_sum[7:0];
    assign col_last    = ({1'b0, r_col} + 9'd1) == {1'b0, r_col_hi};
    assign row_last    = ({1'b0, r_row} + 9'd1) == {1'b0, r_row_end};
    assign scroll_full = (i_row_count == 8'd0) || (i_row_count >= ROWS8);

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_row_end   = r_row_end;
        n_col_lo    = r_col_lo;
        n_col_hi    = r_col_hi;
        n_shift     = r_shift;
        n_item      = r_item;
        n_wr_pend   = r_wr_pend;
        n_wr_addr   = r_wr_addr;
        n_inside    = r_inside;
        n_result    = r_result;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_glyph = r_out_glyph;
        ram_we      = 1'b0;
        ram_waddr   = cur_addr;
        ram_wdata   = txgb_pkg::BLANK_GLYPH;
        ram_raddr   = cur_addr;

        unique case (r_state)
            ST_IDLE: begin
                ram_raddr = in_addr;
                ram_waddr = in_addr;
                ram_wdata = i_glyph_code;
                if (accept) begin
                    n_item   = 1'b1;
                    n_result = '0;
                    n_row    = '0;
                    n_col    = '0;
                    n_col_lo = '0;
                    n_row_end = ROWS8;
                    n_col_hi = COLS8;
                    unique case (txgb_pkg::t_mode'(i_mode))
                        txgb_pkg::MODE_FILL: begin
                            n_state = ST_BLANK;
                        end
                        txgb_pkg::MODE_DRAW: begin
                            ram_we  = in_grid;
                            n_state = ST_RESULT;
                        end
                        txgb_pkg::MODE_CLEAR: begin
                            n_row     = i_row_index;
                            n_col     = i_col_index;
                            n_col_lo  = i_col_index;
                            n_row_end = clr_row_end;
                            n_col_hi  = clr_col_hi;
                            if ((i_row_index >= clr_row_end) ||
                                (i_col_index >= clr_col_hi)) begin
                                n_state = ST_RESULT;
                            end else begin
                                n_state = ST_BLANK;
                            end
                        end
                        txgb_pkg::MODE_SCROLL: begin
                            if (scroll_full) begin
                                n_state = ST_BLANK;
                            end else begin
                                n_row_end = ROWS8 - i_row_count;
                                n_shift   = i_row_count;
                                n_wr_pend = 1'b0;
                                n_state   = ST_COPY;
                            end
                        end
                        txgb_pkg::MODE_READ: begin
                            n_inside = in_grid;
                            n_state  = ST_READ_WAIT;
                        end
                        default: begin
                            n_state = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_BLANK: begin
                ram_we = 1'b1;
                if (col_last) begin
                    n_col = r_col_lo;
                    n_row = r_row + 8'd1;
                    if (row_last) begin
                        n_state = r_item ? ST_RESULT : ST_IDLE;
                    end
                end else begin
                    n_col = r_col + 8'd1;
                end
            end
            ST_COPY: begin
                ram_raddr = src_addr;
                ram_waddr = r_wr_addr;
                ram_wdata = ram_rdata;
                ram_we    = r_wr_pend;
                n_wr_addr = cur_addr;
                n_wr_pend = 1'b1;
                if (col_last) begin
                    n_col = r_col_lo;
                    n_row = r_row + 8'd1;
                    if (row_last) begin
                        n_state = ST_COPY_LAST;
                    end
                end else begin
                    n_col = r_col + 8'd1;
                end
            end
            ST_COPY_LAST: begin
                ram_waddr = r_wr_addr;
                ram_wdata = ram_rdata;
                ram_we    = 1'b1;
                n_wr_pend = 1'b0;
                n_row     = r_row_end;
                n_col     = '0;
                n_row_end = ROWS8;
                n_state   = ST_BLANK;
            end
            ST_READ_WAIT: begin
                n_result = r_inside ? ram_rdata : txgb_pkg::BLANK_GLYPH;
                n_state  = ST_RESULT;
            end
            ST_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_glyph = r_result;
                    n_item      = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_BLANK;
            r_row       <= '0;
            r_col       <= '0;
            r_row_end   <= ROWS8;
            r_col_lo    <= '0;
            r_col_hi    <= COLS8;
            r_item      <= 1'b0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_row_end   <= n_row_end;
            r_col_lo    <= n_col_lo;
            r_col_hi    <= n_col_hi;
            r_item      <= n_item;
            r_wr_pend   <= n_wr_pend;
            r_out_valid <= n_out_valid;
        end
        r_shift     <= n_shift;
        r_wr_addr   <= n_wr_addr;
        r_inside    <= n_inside;
        r_result    <= n_result;
        r_out_glyph <= n_out_glyph;
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_in_stall)
        else $error("block took a second item straight after a transfer");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_RESULT))
        else $error("result presented without passing through the result state");

    a_walk_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BLANK || r_state == ST_COPY) |->
            (r_row < ROWS8 && r_col < COLS8))
        else $error("cell walker left the grid");

    a_copy_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY) |-> (src_row < ROWS8 && r_shift != 8'd0))
        else $error("scroll source row outside the grid");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for text_grid_buffer_engine: commands go in through the
// valid/stall input channel and every read_glyph transfer is checked against a grid model.
// Depends on txgb_pkg and the RTL of the block; it needs no files or arguments.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import txgb_pkg::*;

    localparam int GRID_ROWS = 16;
    localparam int GRID_COLS = 32;
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam int IDLE_PERCENT = 36;
    localparam int RESET_CYCLES = 12;
    localparam int TAIL_CYCLES = 20;
    localparam longint TIMEOUT_NS = 60_000_000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [2:0] i_mode = '0;
    logic [7:0] i_row_index = '0;
    logic [7:0] i_col_index = '0;
    logic [7:0] i_glyph_code = '0;
    logic [7:0] i_row_count = '0;
    logic [7:0] i_col_count = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_read_glyph;

    t_glyph grid_model [GRID_ROWS][GRID_COLS];
    t_glyph pending_glyphs [$];
    int     mismatch_count = 0;
    bit     idling_on = 1'b1;

    text_grid_buffer_engine #(
        .GRID_ROWS(GRID_ROWS),
        .GRID_COLS(GRID_COLS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_mode(i_mode),
        .i_row_index(i_row_index),
        .i_col_index(i_col_index),
        .i_glyph_code(i_glyph_code),
        .i_row_count(i_row_count),
        .i_col_count(i_col_count),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_read_glyph(o_read_glyph)
    );

    always #10 i_clk = ~i_clk;

    function automatic void blank_grid_model();
        int r;
        int c;
        for (r = 0; r < GRID_ROWS; r++) begin
            for (c = 0; c < GRID_COLS; c++) begin
                grid_model[r][c] = BLANK_GLYPH;
            end
        end
    endfunction

    function automatic t_glyph predict_command(input logic [2:0] mode, input logic [7:0] row,
                                               input logic [7:0] col, input logic [7:0] glyph,
                                               input logic [7:0] nrows, input logic [7:0] ncols);
        int     r;
        int     c;
        bit     in_grid;
        t_glyph result;
        in_grid = (row < GRID_ROWS) && (col < GRID_COLS);
        result = '0;
        case (mode)
            MODE_FILL: begin
                blank_grid_model();
            end
            MODE_DRAW: begin
                if (in_grid) begin
                    grid_model[row][col] = glyph;
                end
            end
            MODE_CLEAR: begin
                for (r = row; r < int'(row) + int'(nrows) && r < GRID_ROWS; r++) begin
                    for (c = col; c < int'(col) + int'(ncols) && c < GRID_COLS; c++) begin
                        grid_model[r][c] = BLANK_GLYPH;
                    end
                end
            end
            MODE_SCROLL: begin
                if (nrows == 0 || nrows >= GRID_ROWS) begin
                    blank_grid_model();
                end else begin
                    for (r = 0; r < GRID_ROWS; r++) begin
                        for (c = 0; c < GRID_COLS; c++) begin
                            grid_model[r][c] = (r + nrows < GRID_ROWS) ?
                                               grid_model[r + nrows][c] : BLANK_GLYPH;
                        end
                    end
                end
            end
            MODE_READ: begin
                result = in_grid ? grid_model[row][col] : BLANK_GLYPH;
            end
            default: begin
            end
        endcase
        return result;
    endfunction

    task automatic report_mismatch(input string what, input t_glyph got, input t_glyph want);
        $display("mismatch at %0t ns: %s, got %02h, expected %02h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_glyph want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_glyphs.size() == 0) begin
                report_mismatch("result transfer with no command outstanding", o_read_glyph, '0);
            end else begin
                want = pending_glyphs.pop_front();
                if (o_read_glyph !== want) begin
                    report_mismatch("read_glyph", o_read_glyph, want);
                end
            end
        end
        i_out_stall <= idling_on && ($urandom_range(99) < IDLE_PERCENT);
    end

    task automatic send_command(input logic [2:0] mode, input logic [7:0] row,
                                input logic [7:0] col, input logic [7:0] glyph,
                                input logic [7:0] nrows, input logic [7:0] ncols);
        while (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_row_index  <= row;
        i_col_index  <= col;
        i_glyph_code <= glyph;
        i_row_count  <= nrows;
        i_col_count  <= ncols;
        do @(posedge i_clk); while (o_in_stall);
        pending_glyphs.push_back(predict_command(mode, row, col, glyph, nrows, ncols));
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_glyphs.size() != 0);
    endtask

    task automatic send_random_command();
        int         pick;
        logic [2:0] mode;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] glyph;
        logic [7:0] nrows;
        logic [7:0] ncols;
        pick  = $urandom_range(99);
        row   = 8'($urandom_range(GRID_ROWS - 1));
        col   = 8'($urandom_range(GRID_COLS - 1));
        glyph = 8'($urandom_range(255));
        nrows = 8'($urandom_range(4));
        ncols = 8'($urandom_range(8));
        if (pick < 38) begin
            mode = MODE_DRAW;
        end else if (pick < 76) begin
            mode = MODE_READ;
            if ($urandom_range(7) == 0) begin
                row = 8'($urandom_range(255));
                col = 8'($urandom_range(255));
            end
        end else if (pick < 88) begin
            mode = MODE_CLEAR;
            if ($urandom_range(3) == 0) begin
                nrows = 8'($urandom_range(255));
                ncols = 8'($urandom_range(255));
            end
        end else if (pick < 94) begin
            mode  = MODE_SCROLL;
            nrows = 8'($urandom_range(1, GRID_ROWS - 1));
        end else if (pick < 96) begin
            mode = MODE_FILL;
        end else begin
            mode  = 3'($urandom_range(MODE_SPARE_HI));
            row   = 8'($urandom_range(255));
            col   = 8'($urandom_range(255));
            nrows = 8'($urandom_range(255));
            ncols = 8'($urandom_range(255));
        end
        send_command(mode, row, col, glyph, nrows, ncols);
    endtask

    task automatic test_after_reset();
        send_command(MODE_READ, 8'd0, 8'd0, 8'h00, 8'd0, 8'd0);
        send_command(MODE_READ, 8'(GRID_ROWS - 1), 8'(GRID_COLS - 1), 8'hFF, 8'hFF, 8'hFF);
    endtask

    task automatic test_draw_and_read();
        send_command(MODE_DRAW, 8'd0, 8'd0, 8'h00, 8'd0, 8'd0);
        send_command(MODE_DRAW, 8'(GRID_ROWS - 1), 8'(GRID_COLS - 1), 8'hFF, 8'd0, 8'd0);
        send_command(MODE_DRAW, 8'(GRID_ROWS), 8'd0, 8'h41, 8'd0, 8'd0);
        send_command(MODE_DRAW, 8'd0, 8'(GRID_COLS), 8'h42, 8'd0, 8'd0);
        send_command(MODE_DRAW, 8'hFF, 8'hFF, 8'h43, 8'hFF, 8'hFF);
        send_command(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_command(MODE_READ, 8'(GRID_ROWS - 1), 8'(GRID_COLS - 1), 8'd0, 8'd0, 8'd0);
        send_command(MODE_READ, 8'(GRID_ROWS), 8'd0, 8'd0, 8'd0, 8'd0);
        send_command(MODE_READ, 8'hFF, 8'hFF, 8'd0, 8'd0, 8'd0);
    endtask

    task automatic test_clear_window();
        send_command(MODE_CLEAR, 8'(GRID_ROWS - 1), 8'(GRID_COLS - 1), 8'd0, 8'd0, 8'hFF);
        send_command(MODE_CLEAR, 8'd0, 8'd0, 8'd0, 8'hFF, 8'd0);
        send_command(MODE_CLEAR, 8'(GRID_ROWS), 8'd0, 8'd0, 8'hFF, 8'hFF);
        send_command(MODE_CLEAR, 8'(GRID_ROWS - 2), 8'(GRID_COLS - 2), 8'd0, 8'hFF, 8'hFF);
        send_command(MODE_READ, 8'(GRID_ROWS - 1), 8'(GRID_COLS - 1), 8'd0, 8'd0, 8'd0);
    endtask

    task automatic test_scroll();
        send_command(MODE_DRAW, 8'd1, 8'd5, 8'h5A, 8'd0, 8'd0);
        send_command(MODE_SCROLL, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0);
        send_command(MODE_READ, 8'd0, 8'd5, 8'd0, 8'd0, 8'd0);
        send_command(MODE_SCROLL, 8'd0, 8'd0, 8'd0, 8'(GRID_ROWS - 1), 8'd0);
        send_command(MODE_SCROLL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        send_command(MODE_SCROLL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    endtask

    task automatic test_fill_and_spare_modes();
        int m;
        send_command(MODE_FILL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        for (m = int'(MODE_SPARE_LO); m <= int'(MODE_SPARE_HI); m++) begin
            send_command(3'(m), 8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF);
        end
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_random_command();
    endtask

    task automatic test_without_idling(input int count);
        idling_on = 1'b0;
        repeat (count) send_random_command();
        idling_on = 1'b1;
    endtask

    // The sender stops at intervals until every outstanding transfer has come back.
    task automatic test_drained_pauses(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            if (n % 25 == 24) begin
                hold_until_drained();
            end
            send_random_command();
        end
    endtask

    initial begin
        blank_grid_model();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_after_reset();
        test_draw_and_read();
        test_clear_window();
        test_scroll();
        test_fill_and_spare_modes();
        test_random_traffic(600);
        test_without_idling(250);
        test_drained_pauses(200);
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout at %0t ns, %0d results outstanding", $time, pending_glyphs.size());
        $display("status: fail");
        $finish;
    end

endmodule

// ----- text_grid_buffer_engine.f -----
hw/rtl/txgb_pkg.sv
hw/rtl/txgb_ram.sv
hw/rtl/text_grid_buffer_engine.sv
sim/tb_top.sv
